// File: src/binary_window_threshold_filter_core_defines.svh
// Assertion macros for the binary window threshold filter core
`ifndef BINARY_WINDOW_THRESHOLD_FILTER_CORE_DEFINES_SVH
`define BINARY_WINDOW_THRESHOLD_FILTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked check, muted while reset is asserted
`define BWTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bwtf check failed");
// Clocked check that also holds while reset is asserted
`define BWTF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bwtf reset check failed");
`else
`define BWTF_ASSERT(lbl, prop)
`define BWTF_ASSERT_RST(lbl, prop)
`endif
`endif

// File: src/bwtf_pkg.sv
// Shared constants and types for the binary window threshold filter
package bwtf_pkg;

  // register field widths
  localparam int unsigned DIM_W = 11;
  localparam int unsigned THR_W = 17;

  // default build limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_RADIUS     = 1;

  // register reset values
  localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 11'd1024;
  localparam logic [THR_W-1:0] THRESHOLD_RST  = 17'd32768;

  // APB port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // stream byte lanes
  localparam int unsigned TDATA_W = 8;

  // register word index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_THRESHOLD  = 2'd2
  } cfg_reg_e;

endpackage

// File: src/bwtf_linebuf.sv
// Line buffer: one word of buffered rows per column, registered read with write bypass
module bwtf_linebuf #(
  parameter int unsigned DEPTH  = bwtf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned DATA_W = 2 * bwtf_pkg::DEF_RADIUS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // same-column write in the read cycle (one-column maps): take the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: src/binary_window_threshold_filter_core.sv
// Top level of the binary window threshold filter (cave smoothing cellular automaton step)
// The core takes a binary map one cell per transaction in raster order and returns, for each
// cell, 1 when the ones in the (2*RADIUS+1)^2 window around it (positions off the map count
// as ones) exceed threshold_frac/65536 of the window, compared exactly. One transaction is taken
// every cycle; a result passes the window stage and output register after the input completing
// its window, i.e. result k follows input RADIUS*map_width+RADIUS+k. After the last map cell
// the sender streams RADIUS*map_width+RADIUS pad transactions (tuser=1) to flush the tail;
// a pad inside the frame is dropped, and a cell after the frame counts as a pad. The rate is
// set by the dual-port line buffer (MAX_WIDTH words of 2*RADIUS bits, one read and one
// write per cycle) feeding a column-shift window register; s_axis_tready only drops while
// the output register holds an untaken result and the window stage holds the next one.
// No clearing pass is needed after reset. A write to a defined register restarts the frame.
module binary_window_threshold_filter_core #(
  parameter int unsigned MAX_WIDTH  = bwtf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bwtf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned RADIUS     = bwtf_pkg::DEF_RADIUS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input cell stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bwtf_pkg::TDATA_W-1:0]    s_axis_tdata,  // [0] cell_in, rest zero
  input  logic                            s_axis_tuser,  // [0] pad
  // output cell stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bwtf_pkg::TDATA_W-1:0]    m_axis_tdata,  // [0] cell_out, rest zero
  output logic                            m_axis_tlast,  // frame_end
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bwtf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bwtf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bwtf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

`include "binary_window_threshold_filter_core_defines.svh"

  localparam int unsigned WinN     = 2 * RADIUS + 1;
  localparam int unsigned WinCells = WinN * WinN;
  localparam int unsigned LbW      = 2 * RADIUS;
  localparam int unsigned ColAddrW = $clog2(MAX_WIDTH);
  localparam int unsigned ColW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowAddrW = $clog2(MAX_HEIGHT);
  localparam int unsigned RowW     = $clog2(MAX_HEIGHT + 1);
  // input row runs up to height + 2*RADIUS on a one-column map while the tail flushes
  localparam int unsigned InRowW   = $clog2(MAX_HEIGHT + 2 * RADIUS + 1);
  localparam int unsigned LagW     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int unsigned CntW     = $clog2(WinCells + 1);
  localparam int unsigned ProdW    = bwtf_pkg::THR_W + CntW;
  localparam int          Rad      = RADIUS;

  // ---------------------------------------------------------------- registers
  logic [bwtf_pkg::DIM_W-1:0] map_width_q, map_height_q;
  logic [bwtf_pkg::THR_W-1:0] threshold_q;
  logic                       cfg_wr;
  logic                       cfg_hit;
  bwtf_pkg::cfg_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = bwtf_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata  = '0;
    cfg_hit = 1'b1;
    unique case (cfg_idx)
      bwtf_pkg::REG_MAP_WIDTH:  prdata = bwtf_pkg::APB_DATA_W'(map_width_q);
      bwtf_pkg::REG_MAP_HEIGHT: prdata = bwtf_pkg::APB_DATA_W'(map_height_q);
      bwtf_pkg::REG_THRESHOLD:  prdata = bwtf_pkg::APB_DATA_W'(threshold_q);
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= bwtf_pkg::MAP_WIDTH_RST;
      map_height_q <= bwtf_pkg::MAP_HEIGHT_RST;
      threshold_q  <= bwtf_pkg::THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bwtf_pkg::REG_MAP_WIDTH:  map_width_q  <= pwdata[bwtf_pkg::DIM_W-1:0];
        bwtf_pkg::REG_MAP_HEIGHT: map_height_q <= pwdata[bwtf_pkg::DIM_W-1:0];
        bwtf_pkg::REG_THRESHOLD:  threshold_q  <= pwdata[bwtf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MAX
  logic [ColW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [LagW-1:0] lag;

  always_comb begin
    if (map_width_q == '0) begin
      w_eff = ColW'(1);
    end else if (32'(map_width_q) > MAX_WIDTH) begin
      w_eff = ColW'(MAX_WIDTH);
    end else begin
      w_eff = ColW'(map_width_q);
    end
    if (map_height_q == '0) begin
      h_eff = RowW'(1);
    end else if (32'(map_height_q) > MAX_HEIGHT) begin
      h_eff = RowW'(MAX_HEIGHT);
    end else begin
      h_eff = RowW'(map_height_q);
    end
  end

  // items between a cell entering and its result leaving
  assign lag = LagW'(RADIUS * w_eff + RADIUS);

  // ------------------------------------------------------ stage 0: positions
  logic [ColAddrW-1:0] in_col_q, in_col_d;
  logic [InRowW-1:0]   in_row_q, in_row_d;
  logic [LagW-1:0]     tk_q, tk_d;
  logic [ColAddrW-1:0] ocol_q, ocol_d;
  logic [RowAddrW-1:0] orow_q, orow_d;
  logic                in_frame, accept, take, emit, last, restart;
  logic [ColW-1:0]     col_inc, ocol_inc;
  logic [RowW-1:0]     orow_inc;
  logic                col_wrap, ocol_wrap;
  logic                adv;

  assign in_frame = 32'(in_row_q) < 32'(h_eff);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign take     = accept && !(in_frame && s_axis_tuser);   // pads inside the frame drop
  assign emit     = tk_q >= lag;
  assign col_inc  = ColW'(in_col_q) + ColW'(1);
  assign col_wrap = col_inc >= w_eff;
  assign ocol_inc = ColW'(ocol_q) + ColW'(1);
  assign ocol_wrap = ocol_inc >= w_eff;
  assign orow_inc = RowW'(orow_q) + RowW'(1);
  assign last     = ocol_wrap && (orow_inc >= h_eff);
  assign restart  = (cfg_wr && cfg_hit) || (take && emit && last);

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    tk_d     = tk_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    if (restart) begin
      in_col_d = '0;
      in_row_d = '0;
      tk_d     = '0;
      ocol_d   = '0;
      orow_d   = '0;
    end else if (take) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + InRowW'(1);
      end else begin
        in_col_d = ColAddrW'(col_inc);
      end
      if (emit) begin
        if (ocol_wrap) begin
          ocol_d = '0;
          orow_d = RowAddrW'(orow_inc);
        end else begin
          ocol_d = ColAddrW'(ocol_inc);
        end
      end else begin
        tk_d = tk_q + LagW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      tk_q     <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      tk_q     <= tk_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
    end
  end

  // ------------------------------------------------- stage 1: window column
  logic                s1_valid_q;
  logic                s1_cell_q, s1_emit_q, s1_last_q;
  logic [ColAddrW-1:0] s1_col_q, s1_ocol_q;
  logic [RowAddrW-1:0] s1_orow_q;
  logic                out_valid_q, out_cell_q, out_last_q;

  // stage moves on unless it carries a result and the output register is blocked
  assign adv           = s1_valid_q && (!s1_emit_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cell_q <= s_axis_tdata[0] && in_frame;
      s1_col_q  <= in_col_q;
      s1_emit_q <= emit;
      s1_last_q <= emit && last;
      s1_ocol_q <= ocol_q;
      s1_orow_q <= orow_q;
    end
  end

  // column of the window: bit 0 is the newest row, bit k the row k lines up
  logic [LbW-1:0]  lb_rd_data;
  logic [WinN-1:0] col_in;

  assign col_in = {lb_rd_data, s1_cell_q};

  bwtf_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LbW),
    .ADDR_W (ColAddrW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (in_col_q),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (col_in[LbW-1:0])
  );

  // window register, index a = column age (0 newest)
  logic [WinN-1:0][WinN-1:0] win_q, win_d;

  always_comb begin
    win_d[0] = col_in;
    for (int a = 1; a < WinN; a++) begin
      win_d[a] = win_q[a-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      win_q <= win_d;
    end
  end

  // edge masks and ones count; off-map positions count as ones
  logic [WinN-1:0]  rmask, cmask;
  logic [CntW-1:0]  cnt;
  logic [ProdW-1:0] thr_prod;
  logic             hit;

  always_comb begin
    int rp;
    int cp;
    rmask = '0;
    cmask = '0;
    cnt   = '0;
    for (int m = 0; m < WinN; m++) begin
      rp = int'({1'b0, s1_orow_q}) + Rad - m;
      rmask[m] = (rp >= 0) && (rp < int'({1'b0, h_eff}));
    end
    for (int a = 0; a < WinN; a++) begin
      cp = int'({1'b0, s1_ocol_q}) + Rad - a;
      cmask[a] = (cp >= 0) && (cp < int'({1'b0, w_eff}));
    end
    for (int a = 0; a < WinN; a++) begin
      for (int m = 0; m < WinN; m++) begin
        cnt = cnt + CntW'(win_d[a][m] || !(rmask[m] && cmask[a]));
      end
    end
  end

  // cnt*65536 > thr*cells  <=>  cnt > floor(thr*cells / 65536)
  assign thr_prod = ProdW'(threshold_q) * ProdW'(WinCells);
  assign hit      = 32'(cnt) > 32'(thr_prod[ProdW-1:16]);

  // -------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_emit_q) begin
      out_cell_q <= hit;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bwtf_pkg::TDATA_W-1){1'b0}}, out_cell_q};
  assign m_axis_tlast  = out_last_q;

  // ------------------------------------------------------------- checks
  `BWTF_ASSERT(a_stall_only_when_full, !s_axis_tready |-> (s1_valid_q && s1_emit_q && out_valid_q))
  `BWTF_ASSERT(a_fill_count_bounded, tk_q <= lag)
  `BWTF_ASSERT(a_out_row_in_map, 32'(orow_q) < 32'(h_eff))
  `BWTF_ASSERT(a_result_reaches_port, (adv && s1_emit_q) |=> m_axis_tvalid)
  // flops clear asynchronously while reset is asserted; the outputs are checked at the next edge
  `BWTF_ASSERT_RST(a_reset_quiet, !rst_ni |=> (!m_axis_tvalid && !s1_valid_q))

endmodule
